// ===== hdl/bu8_pkg.sv =====
`default_nettype none

package bu8_pkg;

   // Item kinds carried in req_tuser
   localparam logic [1:0] KIND_INNER  = 2'd0;
   localparam logic [1:0] KIND_FINAL  = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int KIND_W     = 2;
   localparam int BYTE_W     = 8;
   localparam int CP_W       = 21;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_OK   = 1'b1;

   localparam logic [CSR_DATA_W-1:0] MAX_LENGTH_RESET = 16'd256;
   localparam logic                  EMPTY_OK_RESET   = 1'b0;
   localparam int                    LENGTH_BITS_DEFAULT = 16;

   // Byte classes
   localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
   localparam logic [BYTE_W-1:0] DEL_BYTE   = 8'h7F;
   localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hF4;

   // Code point limits
   localparam logic [CP_W-1:0] CP_MIN3  = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN4  = 21'h010000;
   localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
   localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;

   // Sequence state of the string being checked
   typedef struct packed {
      logic [1:0]      pending;
      logic [1:0]      seq_len;
      logic [CP_W-1:0] cp_acc;
      logic            reject;
   } seq_state_type;

   localparam seq_state_type SEQ_CLEAR = '{pending: 2'd0, seq_len: 2'd0,
                                           cp_acc: '0, reject: 1'b0};

endpackage

`default_nettype wire

// ===== hdl/bu8_step.sv =====
`default_nettype none

module bu8_step #(
   parameter int LENGTH_BITS = bu8_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire bu8_pkg::seq_state_type         cur_state,
   input  wire logic [LENGTH_BITS:0]           cur_count,
   input  wire logic [1:0]                     kind,
   input  wire logic [7:0]                     data_byte,
   input  wire logic [bu8_pkg::CSR_DATA_W-1:0] max_length,
   input  wire logic                           empty_ok,
   output bu8_pkg::seq_state_type              nxt_state,
   output logic [LENGTH_BITS:0]                nxt_count,
   output logic                                has_rsp,
   output logic                                rsp_accepted
);
   import bu8_pkg::*;

   localparam int CNT_W = LENGTH_BITS + 1;
   localparam int CMP_W = (CNT_W > CSR_DATA_W) ? CNT_W : CSR_DATA_W;

   seq_state_type     tk_state;
   logic [CNT_W-1:0]  tk_count;
   logic [CP_W-1:0]   cp_shift;
   logic [1:0]        pend_dec;
   logic              len_ok;

   // Byte update, as if the byte were taken
   always_comb begin
      tk_state = cur_state;
      tk_count = (cur_count != {CNT_W{1'b1}}) ? cur_count + 1'b1 : cur_count;
      cp_shift = {cur_state.cp_acc[CP_W-7:0], data_byte[5:0]};
      pend_dec = cur_state.pending - 2'd1;

      if (data_byte < CTRL_LIMIT || data_byte == DEL_BYTE) begin
         tk_state.reject = 1'b1;
      end

      if (cur_state.pending == 2'd0) begin
         if (data_byte <= DEL_BYTE) begin
            // plain ASCII, nothing to open
         end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
            tk_state.pending = 2'd1;
            tk_state.seq_len = 2'd1;
            tk_state.cp_acc  = {{(CP_W-5){1'b0}}, data_byte[4:0]};
         end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
            tk_state.pending = 2'd2;
            tk_state.seq_len = 2'd2;
            tk_state.cp_acc  = {{(CP_W-4){1'b0}}, data_byte[3:0]};
         end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
            tk_state.pending = 2'd3;
            tk_state.seq_len = 2'd3;
            tk_state.cp_acc  = {{(CP_W-3){1'b0}}, data_byte[2:0]};
         end else begin
            tk_state.reject = 1'b1;
         end
      end else if (data_byte[7:6] != 2'b10) begin
         // bad continuation: close the open sequence
         tk_state.reject  = 1'b1;
         tk_state.pending = 2'd0;
         tk_state.seq_len = 2'd0;
         tk_state.cp_acc  = '0;
      end else begin
         tk_state.pending = pend_dec;
         tk_state.cp_acc  = cp_shift;
         if (pend_dec == 2'd0) begin
            if ((cur_state.seq_len == 2'd2 && cp_shift < CP_MIN3) ||
                (cur_state.seq_len == 2'd3 && cp_shift < CP_MIN4) ||
                (cp_shift >= SURR_LO && cp_shift <= SURR_HI) ||
                cp_shift > CP_MAX) begin
               tk_state.reject = 1'b1;
            end
            tk_state.seq_len = 2'd0;
            tk_state.cp_acc  = '0;
         end
      end
   end

   assign len_ok = CMP_W'(tk_count) <= CMP_W'(max_length);

   always_comb begin
      nxt_state    = cur_state;
      nxt_count    = cur_count;
      has_rsp      = 1'b0;
      rsp_accepted = 1'b0;
      unique case (kind)
         KIND_INNER: begin
            nxt_state = tk_state;
            nxt_count = tk_count;
         end
         KIND_FINAL: begin
            nxt_state    = SEQ_CLEAR;
            nxt_count    = '0;
            has_rsp      = 1'b1;
            rsp_accepted = !tk_state.reject && tk_state.pending == 2'd0 && len_ok;
         end
         KIND_EMPTY: begin
            nxt_state    = SEQ_CLEAR;
            nxt_count    = '0;
            has_rsp      = 1'b1;
            rsp_accepted = empty_ok;
         end
         default: begin
            // unused kind: no result, state holds
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/bounded_utf8_text_checker.sv =====
`default_nettype none

// Channel  Direction  Ports                          Contents
// req      in         req_tvalid/tready/tdata/tuser  tdata: data_byte; tuser: kind
// rsp      out        rsp_tvalid/tready/tdata        tdata[0]: accepted, rest zero
// csr      in         csr_we/csr_index/csr_wdata     0: max_length, 1: empty enable
//
// One byte transaction per cycle while back-pressure on rsp does not stall the input.
// A byte lands in the input register, is checked against the string state in the next
// cycle, and a final or empty transaction has its result registered and shown on rsp.
// Synchronous active-high reset clears the string state, both valid flags and
// the CSRs to their defaults. Back-pressure on rsp holds only a transaction that
// carries a result in the input register, and the input stalls behind it;
// inner bytes keep flowing while a result waits.

module bounded_utf8_text_checker #(
   parameter int LENGTH_BITS = bu8_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] data_byte
   input  wire logic [1:0]                      req_tuser,   // [1:0] kind
   // response stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [0] accepted, [7:1] zero
   // configuration writes
   input  wire logic                            csr_we,
   input  wire logic [bu8_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bu8_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bu8_pkg::*;

   // configuration
   logic [CSR_DATA_W-1:0] max_len_ff, max_len_in;
   logic                  empty_ok_ff, empty_ok_in;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]     s1_kind_ff;
   logic [BYTE_W-1:0]     s1_byte_ff;

   // string state
   seq_state_type         st_ff, st_in;
   logic [LENGTH_BITS:0]  count_ff, count_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_acc_ff, rsp_acc_in;

   seq_state_type         dec_state;
   logic [LENGTH_BITS:0]  dec_count;
   logic                  dec_has_rsp;
   logic                  dec_accepted;
   logic                  out_free;
   logic                  s1_go;

   bu8_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .cur_state    (st_ff),
      .cur_count    (count_ff),
      .kind         (s1_kind_ff),
      .data_byte    (s1_byte_ff),
      .max_length   (max_len_ff),
      .empty_ok     (empty_ok_ff),
      .nxt_state    (dec_state),
      .nxt_count    (dec_count),
      .has_rsp      (dec_has_rsp),
      .rsp_accepted (dec_accepted)
   );

   // The result register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;
   // Advance the held transaction unless its result has nowhere to go.
   assign s1_go    = s1_valid_ff && (!dec_has_rsp || out_free);

   assign req_tready = !s1_valid_ff || s1_go;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_acc_ff};

   // CSR decode
   always_comb begin
      max_len_in  = max_len_ff;
      empty_ok_in = empty_ok_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_LENGTH: max_len_in  = csr_wdata;
            CSR_EMPTY_OK:   empty_ok_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end

      st_in    = st_ff;
      count_in = count_ff;
      if (s1_go) begin
         st_in    = dec_state;
         count_in = dec_count;
      end

      // Load a new result, else drop the taken one, else hold.
      rsp_valid_in = rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      if (s1_go && dec_has_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_acc_in   = dec_accepted;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LENGTH_RESET;
         empty_ok_ff  <= EMPTY_OK_RESET;
         s1_valid_ff  <= 1'b0;
         st_ff        <= SEQ_CLEAR;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         empty_ok_ff  <= empty_ok_in;
         s1_valid_ff  <= s1_valid_in;
         st_ff        <= st_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_kind_ff <= req_tuser;
         s1_byte_ff <= req_tdata;
      end
      rsp_acc_ff <= rsp_acc_in;
   end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
module tb;

   import bu8_pkg::*;

   localparam int LEN_BITS = LENGTH_BITS_DEFAULT;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;   // [7:0] data_byte
   logic [1:0]            req_tuser  = KIND_INNER;  // [1:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;            // [0] accepted, [7:1] zero
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_MAX_LENGTH;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   bounded_utf8_text_checker #(.LENGTH_BITS(LEN_BITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the checker: configuration and per-string state.
   logic [CSR_DATA_W-1:0] max_len_cfg     = MAX_LENGTH_RESET;
   logic                  empty_ok_cfg    = EMPTY_OK_RESET;
   logic [1:0]            seq_pending     = '0;
   logic [1:0]            seq_len         = '0;
   logic [CP_W-1:0]       cp_acc          = '0;
   logic [LEN_BITS:0]     str_bytes       = '0;
   logic                  str_fault       = 1'b0;

   logic verdict_q[$];      // verdicts still owed by the block, oldest first
   int   items_sent     = 0;
   int   mismatch_count = 0;
   bit   gaps_on        = 1'b0;   // random idling on both channels
   int   rsp_hold_len   = 0;      // request for one long receiver hold-off

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Give up after a fixed time; a correct run finishes far earlier.
   initial begin
      #40_000_000;
      $display("bounded_utf8_text_checker verification failed");
      $finish;
   end

   function automatic void clear_text_state();
      seq_pending = '0;
      seq_len     = '0;
      cp_acc      = '0;
      str_bytes   = '0;
      str_fault   = 1'b0;
   endfunction

   // Advance the shadow state by one transaction; return 1 when the block owes a
   // verdict for it, with that verdict in text_ok.
   function automatic bit check_text_byte(input logic [1:0] kind, input logic [7:0] data,
                                          output logic text_ok);
      logic [CP_W-1:0] cp;
      text_ok = 1'b0;
      if (kind == KIND_UNUSED)
         return 1'b0;
      if (kind == KIND_EMPTY) begin
         // empty string, also drops any partial string
         text_ok = empty_ok_cfg;
         clear_text_state();
         return 1'b1;
      end
      // saturate the byte counter so a huge string never wraps back under the limit
      if (str_bytes != '1)
         str_bytes = str_bytes + 1'b1;
      if (data < CTRL_LIMIT || data == DEL_BYTE)
         str_fault = 1'b1;
      if (seq_pending == 2'd0) begin
         if (data <= DEL_BYTE) begin
            // plain ASCII, nothing to open
         end else if (data >= LEAD2_LO && data <= LEAD2_HI) begin
            seq_pending = 2'd1;
            seq_len     = 2'd1;
            cp_acc      = CP_W'(data & 8'h1F);
         end else if (data >= LEAD3_LO && data <= LEAD3_HI) begin
            seq_pending = 2'd2;
            seq_len     = 2'd2;
            cp_acc      = CP_W'(data & 8'h0F);
         end else if (data >= LEAD4_LO && data <= LEAD4_HI) begin
            seq_pending = 2'd3;
            seq_len     = 2'd3;
            cp_acc      = CP_W'(data & 8'h07);
         end else begin
            str_fault = 1'b1;
         end
      end else if (data[7:6] != 2'b10) begin
         // bad continuation closes the open sequence
         str_fault   = 1'b1;
         seq_pending = '0;
         seq_len     = '0;
         cp_acc      = '0;
      end else begin
         cp_acc      = {cp_acc[CP_W-7:0], data[5:0]};
         seq_pending = seq_pending - 2'd1;
         if (seq_pending == 2'd0) begin
            cp = cp_acc;
            if ((seq_len == 2'd2 && cp < CP_MIN3) || (seq_len == 2'd3 && cp < CP_MIN4) ||
                (cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX)
               str_fault = 1'b1;
            seq_len = '0;
            cp_acc  = '0;
         end
      end
      if (kind == KIND_INNER)
         return 1'b0;
      text_ok = !str_fault && seq_pending == 2'd0 && str_bytes <= max_len_cfg;
      clear_text_state();
      return 1'b1;
   endfunction

   // Offer one transaction, hold it until the block takes it, then predict.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] data);
      logic text_ok;
      int   gap;
      gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (check_text_byte(kind, data, text_ok))
         verdict_q.insert(verdict_q.size(), text_ok);
      if (kind != KIND_UNUSED)
         items_sent++;
   endtask

   // Send the low n bytes of word, highest byte first.
   task automatic send_bytes(input logic [31:0] word, input int n, input bit ends_string);
      for (int i = n - 1; i >= 0; i--)
         send_item((ends_string && i == 0) ? KIND_FINAL : KIND_INNER, word[8*i +: 8]);
   endtask

   // One string of n printable bytes.
   task automatic send_long(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom_range(32, 126));
         send_item((i == n - 1) ? KIND_FINAL : KIND_INNER, b);
      end
   endtask

   // Stop offering, wait for every owed verdict, then let the pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers on back-to-back edges; call only while idle.
   task automatic set_limits(input logic [CSR_DATA_W-1:0] max_len,
                             input logic [CSR_DATA_W-1:0] empty_word);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_LENGTH;
      csr_wdata <= max_len;
      @(posedge clock);
      csr_index <= CSR_EMPTY_OK;
      csr_wdata <= empty_word;
      @(posedge clock);
      csr_we <= 1'b0;
      max_len_cfg  = max_len;
      empty_ok_cfg = empty_word[0];
   endtask

   // Build one character as up to four bytes (high byte first); a few come out
   // overlong, surrogate, out of range, truncated or with a broken continuation.
   function automatic int make_char(output logic [31:0] w);
      logic [CP_W-1:0] cp;
      int n;
      int pick;
      pick = $urandom_range(0, 99);
      w    = '0;
      cp   = '0;
      if (pick < 45) begin
         n = 1;
         if ($urandom_range(0, 9) == 0)
            w[7:0] = 8'($urandom_range(0, 127));
         else
            w[7:0] = 8'($urandom_range(32, 126));
      end else if (pick < 60) begin
         n  = 2;
         if ($urandom_range(0, 19) == 0)
            cp = CP_W'($urandom_range(0, 'h7F));
         else
            cp = CP_W'($urandom_range('h80, 'h7FF));
      end else if (pick < 80) begin
         n = 3;
         case ($urandom_range(0, 9))
            0:       cp = CP_W'($urandom_range('h7C0, 'h840));
            1:       cp = CP_W'($urandom_range('hD7C0, 'hE040));
            default: cp = CP_W'($urandom_range('h800, 'hFFFF));
         endcase
      end else if (pick < 95) begin
         n = 4;
         case ($urandom_range(0, 9))
            0:       cp = CP_W'($urandom_range('hFFC0, 'h10040));
            1:       cp = CP_W'($urandom_range('h10FFC0, 'h110040));
            2:       cp = CP_W'($urandom_range('h110000, 'h1FFFFF));
            default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
         endcase
      end else begin
         n = $urandom_range(1, 4);
         w = $urandom;
      end
      // raw encodings: small values give overlong forms, high ones F5-F7 leads
      if (pick >= 45 && pick < 95) begin
         case (n)
            2: w = {16'h0, 8'hC0 | cp[10:6], 8'h80 | cp[5:0]};
            3: w = {8'h0, 8'hE0 | cp[15:12], 8'h80 | cp[11:6], 8'h80 | cp[5:0]};
            default: w = {8'hF0 | cp[20:18], 8'h80 | cp[17:12], 8'h80 | cp[11:6],
                          8'h80 | cp[5:0]};
         endcase
      end
      if (n > 1 && $urandom_range(0, 24) == 0) begin
         if ($urandom_range(0, 1) == 1) begin
            w = w >> 8;   // drop the last byte
            n--;
         end else begin
            w[7:0] = 8'($urandom_range(0, 255));
         end
      end
      return n;
   endfunction

   task automatic send_random_string(input int max_chars);
      logic [31:0] w;
      int n;
      int chars;
      chars = $urandom_range(1, max_chars);
      for (int c = 0; c < chars; c++) begin
         n = make_char(w);
         // sprinkle ignored kinds and mid-string empties
         if ($urandom_range(0, 49) == 0)
            send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 99) == 0)
            send_item(KIND_EMPTY, 8'($urandom_range(0, 255)));
         send_bytes(w, n, c == chars - 1);
      end
   endtask

   // Reset values: max length 256, empty rejected.
   task automatic test_single_bytes();
      send_item(KIND_EMPTY, 8'hFF);
      send_bytes(32'h41, 1, 1'b1);
      send_bytes(32'h00, 1, 1'b1);
      send_bytes(32'h1F, 1, 1'b1);
      send_bytes(32'h20, 1, 1'b1);
      send_bytes(32'h7E, 1, 1'b1);
      send_bytes(32'h7F, 1, 1'b1);
      send_bytes(32'h80, 1, 1'b1);
      send_bytes(32'hFF, 1, 1'b1);
      drain();
   endtask

   task automatic test_sequences();
      send_bytes(32'hC1BF, 2, 1'b1);       // overlong two-byte lead
      send_bytes(32'hC280, 2, 1'b1);
      send_bytes(32'hDFBF, 2, 1'b1);
      send_bytes(32'hE09FBF, 3, 1'b1);     // overlong three-byte
      send_bytes(32'hE0A080, 3, 1'b1);
      send_bytes(32'hED9FBF, 3, 1'b1);
      send_bytes(32'hEDA080, 3, 1'b1);     // surrogate
      send_bytes(32'hEFBFBF, 3, 1'b1);
      send_bytes(32'hF08FBFBF, 4, 1'b1);   // overlong four-byte
      send_bytes(32'hF0908080, 4, 1'b1);
      send_bytes(32'hF48FBFBF, 4, 1'b1);
      send_bytes(32'hF4908080, 4, 1'b1);   // above the code point range
      send_bytes(32'hF5808080, 4, 1'b1);
      drain();
   endtask

   task automatic test_framing();
      send_bytes(32'hC241, 2, 1'b1);       // bad continuation
      send_bytes(32'hE282, 2, 1'b1);       // truncated at end of string
      send_item(KIND_UNUSED, 8'h41);       // ignored outside a string
      send_item(KIND_INNER, 8'hC2);
      send_item(KIND_EMPTY, 8'h00);        // drop the partial string
      send_bytes(32'h41, 1, 1'b1);
      send_item(KIND_INNER, 8'h41);
      send_item(KIND_UNUSED, 8'hC2);       // must not open a sequence
      send_item(KIND_FINAL, 8'h42);
      drain();
      set_limits(MAX_LENGTH_RESET, 16'd1);
      send_bytes(32'hE282, 2, 1'b0);
      send_item(KIND_EMPTY, 8'hA5);
      send_item(KIND_EMPTY, 8'h00);
      drain();
   endtask

   // Hold rsp off long enough to fill the block, keep offering, then pause.
   task automatic test_backpressure();
      gaps_on      = 1'b0;
      rsp_hold_len = 300;
      for (int i = 0; i < 60; i++) begin
         if (i % 8 == 7)
            send_bytes(32'hE282AC, 3, 1'b1);
         else
            send_bytes(32'h41 + i, 1, 1'b1);
      end
      drain();
   endtask

   task automatic test_random_text(input int goal, input bit with_gaps);
      logic [CSR_DATA_W-1:0] limit;
      int target;
      int phase_start;
      target = items_sent + goal;
      while (items_sent < target) begin
         drain();
         case ($urandom_range(0, 5))
            0:       limit = '0;
            1:       limit = 16'd1;
            2:       limit = 16'hFFFF;
            3:       limit = MAX_LENGTH_RESET;
            default: limit = 16'($urandom_range(2, 40));
         endcase
         set_limits(limit, 16'($urandom_range(0, 16'hFFFF)));
         gaps_on     = with_gaps && ($urandom_range(0, 2) != 0);
         phase_start = items_sent;
         while (items_sent - phase_start < 150 && items_sent < target) begin
            if ($urandom_range(0, 11) == 0)
               send_item(KIND_EMPTY, 8'($urandom_range(0, 255)));
            else
               send_random_string(($urandom_range(0, 9) == 0) ? 60 : 10);
         end
      end
      drain();
   endtask

   task automatic test_length_limits();
      gaps_on = 1'b0;
      drain();
      set_limits('0, 16'd1);               // zero limit rejects any non-empty string
      send_bytes(32'h41, 1, 1'b1);
      send_item(KIND_EMPTY, 8'h00);
      drain();
      set_limits(16'd1, 16'd0);
      send_bytes(32'h41, 1, 1'b1);
      send_bytes(32'h4142, 2, 1'b1);
      send_bytes(32'hC280, 2, 1'b1);
      send_item(KIND_EMPTY, 8'h00);
      drain();
      set_limits(16'd2, 16'd1);
      send_bytes(32'hC280, 2, 1'b1);
      send_bytes(32'hE282AC, 3, 1'b1);
      drain();
      // strings just under, at and just over the limit
      set_limits(16'd100, 16'd0);
      send_long(99);
      send_long(100);
      send_long(101);
      drain();
   endtask

   // Receiver: random stalls while gaps_on, plus the long hold-off on request.
   initial begin : rsp_pacer
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            stall_left   = rsp_hold_len;
            rsp_hold_len = 0;
         end else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare every rsp transaction with the oldest owed verdict.
   initial begin : verdict_checker
      logic [7:0] want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = {7'd0, verdict_q.pop_front()};
               if (rsp_tdata !== want) begin
                  $display("%0t: result mismatch, expected %h, got %h", $time, want, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : test_sequence
      int waited;
      waited = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_single_bytes();
      test_sequences();
      test_framing();
      test_backpressure();
      test_random_text(1000, 1'b1);
      test_length_limits();
      // finish with a stretch free of idling
      test_random_text(300, 1'b0);

      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $display("%0t: %0d results never arrived, expected %h, got none", $time,
                  verdict_q.size(), verdict_q[0]);
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("bounded_utf8_text_checker verification clean");
      else
         $display("bounded_utf8_text_checker verification failed");
      $finish;
   end

endmodule

// ===== bounded_utf8_text_checker.f =====
hdl/bu8_pkg.sv
hdl/bu8_step.sv
hdl/bounded_utf8_text_checker.sv
sim/tb.sv
